// File: hdl/hssp_pkg.sv
// hssp_pkg: shared types and constants of the hourly servo slew positioner
// no dependencies; used by hssp_slew and the top level by scoped names
`timescale 1ns / 1ps
`default_nettype none

package hssp_pkg;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 22;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_UPDATE_INTERVAL = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_DEGREES    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_DURATION   = 2'd2;

    localparam logic [15:0] RST_UPDATE_INTERVAL = 16'd20;
    localparam logic [6:0]  RST_STEP_DEGREES    = 7'd1;
    localparam logic [21:0] RST_HOLD_DURATION   = 22'd60000;

    localparam logic [7:0] ANGLE_LOW  = 8'd90;
    localparam logic [7:0] ANGLE_HIGH = 8'd180;
    localparam logic [4:0] NO_HOUR    = 5'd31;

    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 8;
    localparam int unsigned OUT_TUSER_W = 3;

    typedef struct packed {
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic        time_valid;
        logic [31:0] now_ms;
    } t_tick;

    typedef struct packed {
        logic       reached;
        logic       moving;
        logic       position_written;
        logic [7:0] position_deg;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/hssp_slew.sv
// hssp_slew: configuration registers, positioner state and the per-beat update
// depends on hssp_pkg
`timescale 1ns / 1ps
`default_nettype none

module hssp_slew (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire [hssp_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire [hssp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire                                  i_step_en,
    input  hssp_pkg::t_tick                      i_tick,
    output hssp_pkg::t_result                    o_result
);

    logic [15:0] r_update_interval;
    logic [6:0]  r_step_degrees;
    logic [21:0] r_hold_duration;

    logic [7:0]  r_cur_angle, n_cur_angle;
    logic [7:0]  r_tgt_angle, n_tgt_angle;
    logic        r_move_active, n_move_active;
    logic [31:0] r_last_step, n_last_step;
    logic [31:0] r_deadline, n_deadline;
    logic [4:0]  r_last_hour, n_last_hour;

    logic        fire;
    logic        ret;
    logic        due;
    logic [7:0]  tgt_mid;
    logic [31:0] deadline_mid;
    logic [31:0] elapsed;
    logic [8:0]  up_sum;
    logic [7:0]  down_diff;
    logic [8:0]  raw_next;
    logic [7:0]  clamped;
    logic        written;
    logic        reached;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_update_interval <= hssp_pkg::RST_UPDATE_INTERVAL;
            r_step_degrees    <= hssp_pkg::RST_STEP_DEGREES;
            r_hold_duration   <= hssp_pkg::RST_HOLD_DURATION;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                hssp_pkg::CFG_UPDATE_INTERVAL: r_update_interval <= i_cfg_data[15:0];
                hssp_pkg::CFG_STEP_DEGREES:    r_step_degrees    <= i_cfg_data[6:0];
                hssp_pkg::CFG_HOLD_DURATION:   r_hold_duration   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        fire = i_tick.time_valid && (i_tick.minute == 6'd0) && (i_tick.hour != r_last_hour);
        tgt_mid      = fire ? hssp_pkg::ANGLE_LOW : r_tgt_angle;
        deadline_mid = fire ? (i_tick.now_ms + {10'd0, r_hold_duration}) : r_deadline;
        ret = (tgt_mid == hssp_pkg::ANGLE_LOW) && (i_tick.now_ms >= deadline_mid);

        elapsed = i_tick.now_ms - r_last_step;
        due     = elapsed >= {16'd0, r_update_interval};

        up_sum    = {1'b0, r_cur_angle} + {2'd0, r_step_degrees};
        down_diff = r_cur_angle - {1'b0, r_step_degrees};

        n_tgt_angle   = ret ? hssp_pkg::ANGLE_HIGH : tgt_mid;
        n_deadline    = deadline_mid;
        n_last_hour   = fire ? i_tick.hour : r_last_hour;
        n_move_active = r_move_active || fire || ret;
        n_cur_angle   = r_cur_angle;
        n_last_step   = r_last_step;
        written       = 1'b0;
        reached       = 1'b0;

        // moving up adds, moving down floors at zero before the clamp
        if (n_tgt_angle > r_cur_angle) begin
            raw_next = up_sum;
        end else if ({1'b0, r_step_degrees} >= r_cur_angle) begin
            raw_next = 9'd0;
        end else begin
            raw_next = {1'b0, down_diff};
        end
        if (raw_next < {1'b0, hssp_pkg::ANGLE_LOW}) begin
            clamped = hssp_pkg::ANGLE_LOW;
        end else if (raw_next > {1'b0, hssp_pkg::ANGLE_HIGH}) begin
            clamped = hssp_pkg::ANGLE_HIGH;
        end else begin
            clamped = raw_next[7:0];
        end

        if (due) begin
            if (r_cur_angle != n_tgt_angle) begin
                n_cur_angle = clamped;
                n_last_step = i_tick.now_ms;
                written     = 1'b1;
            end else if (n_move_active) begin
                n_move_active = 1'b0;
                reached       = 1'b1;
            end
        end

        // invalid time leaves everything untouched
        if (!i_tick.time_valid) begin
            n_tgt_angle   = r_tgt_angle;
            n_deadline    = r_deadline;
            n_last_hour   = r_last_hour;
            n_move_active = r_move_active;
            n_cur_angle   = r_cur_angle;
            n_last_step   = r_last_step;
            written       = 1'b0;
            reached       = 1'b0;
        end

        o_result.position_deg     = n_cur_angle;
        o_result.position_written = written;
        o_result.moving           = n_move_active;
        o_result.reached          = reached;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_angle   <= hssp_pkg::ANGLE_HIGH;
            r_tgt_angle   <= hssp_pkg::ANGLE_HIGH;
            r_move_active <= 1'b0;
            r_last_step   <= 32'd0;
            r_deadline    <= 32'd0;
            r_last_hour   <= hssp_pkg::NO_HOUR;
        end else if (i_step_en) begin
            r_cur_angle   <= n_cur_angle;
            r_tgt_angle   <= n_tgt_angle;
            r_move_active <= n_move_active;
            r_last_step   <= n_last_step;
            r_deadline    <= n_deadline;
            r_last_hour   <= n_last_hour;
        end
    end

endmodule

`default_nettype wire

// File: hdl/hourly_servo_slew_positioner.sv
// channel   dir  tdata (low bit up)                          tuser (low bit up)
// s_axis    in   now_ms[31:0] hour[36:32] minute[42:37] zero  time_valid
// m_axis    out  position_deg[7:0]                           position_written moving reached
// cfg       in   i_cfg_we, i_cfg_addr (register index), i_cfg_data
//
// one beat per cycle in and out unless m_axis stalls; input register, then output register
// the state update of one beat completes in the cycle it leaves the input register
// stalls on m_axis hold the output register; s_axis stays ready while the input
// register can move on; synchronous active-low reset empties both registers
// top level of the hourly servo slew positioner; depends on hssp_pkg and hssp_slew
`timescale 1ns / 1ps
`default_nettype none

module hourly_servo_slew_positioner (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // now_ms, hour, minute, zero fill
    input  wire [hssp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // time_valid
    input  wire                                  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // position_deg
    output logic [hssp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // position_written, moving, reached
    output logic [hssp_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    input  wire                                  i_cfg_we,
    input  wire [hssp_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  wire [hssp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic              r_in_valid;
    hssp_pkg::t_tick   r_in;
    logic              r_out_valid;
    hssp_pkg::t_result r_out;
    hssp_pkg::t_result result;
    logic              advance;
    logic              step_en;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign step_en       = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.now_ms     <= s_axis_tdata[31:0];
            r_in.hour       <= s_axis_tdata[36:32];
            r_in.minute     <= s_axis_tdata[42:37];
            r_in.time_valid <= s_axis_tuser;
        end
    end

    hssp_slew u_slew (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_step_en  (step_en),
        .i_tick     (r_in),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.position_deg;
    assign m_axis_tuser  = {r_out.reached, r_out.moving, r_out.position_written};

endmodule

`default_nettype wire

// File: hdl/hssp_checker.sv
// hssp_checker: port-level checks of the hourly servo slew positioner
// no package dependency; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module hssp_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       m_axis_tvalid,
    input wire       m_axis_tready,
    input wire [7:0] m_axis_tdata,
    input wire [2:0] m_axis_tuser
);

    // angle always stays within the clamp range
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata >= 8'd90) && (m_axis_tdata <= 8'd180))
        else $error("position out of range");

    // a beat that ends a move shows the move as finished
    a_reached_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> !m_axis_tuser[1])
        else $error("reached while still moving");

    // a step and the end of a move never share a beat
    a_written_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[2]))
        else $error("step and reached in one beat");

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output beat changed while stalled");

endmodule

bind hourly_servo_slew_positioner hssp_checker u_hssp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: tb/tb_hourly_servo_slew_positioner.sv
// testbench for hourly_servo_slew_positioner: random and directed ticks on s_axis,
// a per-tick servo predictor, and a scoreboard checking every m_axis beat
// depends on hssp_pkg and the hourly_servo_slew_positioner top level
`timescale 1ns / 1ps

module tb_hourly_servo_slew_positioner;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned PHASE_TICKS = 185;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [hssp_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             s_axis_tuser = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [hssp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [hssp_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
    logic                             i_cfg_we = 1'b0;
    logic [hssp_pkg::CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [hssp_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    hourly_servo_slew_positioner u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // now_ms, hour, minute, zero fill
        .s_axis_tuser  (s_axis_tuser),   // time_valid
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // position_deg
        .m_axis_tuser  (m_axis_tuser),   // position_written, moving, reached
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // servo predictor: configuration and state
    logic [15:0] step_interval_ms;
    logic [6:0]  step_deg;
    logic [21:0] hold_ms;
    logic [7:0]  pos_angle;
    logic [7:0]  goal_angle;
    logic        slewing;
    logic [31:0] last_step_ms;
    logic [31:0] return_ms;
    logic [4:0]  fired_hour;

    hssp_pkg::t_tick   pending_ticks[$];
    hssp_pkg::t_result expected_positions[$];
    hssp_pkg::t_tick   tick_on_bus;

    int unsigned send_idle_pct = 24;
    int unsigned recv_idle_pct = 55;
    bit          backpressure_req = 1'b0;
    bit          backpressure_done = 1'b0;
    int unsigned backpressure_cycles = 0;
    int unsigned ticks_sent = 0;
    int unsigned beats_checked = 0;
    int unsigned error_cnt = 0;
    int unsigned settings_used = 1;
    int unsigned cycle_cnt = 0;

    // wall clock used to build well-formed tick sequences
    logic [31:0] sim_ms;
    int unsigned wall_hour;
    int unsigned wall_min;

    function automatic void servo_reset_state();
        step_interval_ms = hssp_pkg::RST_UPDATE_INTERVAL;
        step_deg         = hssp_pkg::RST_STEP_DEGREES;
        hold_ms          = hssp_pkg::RST_HOLD_DURATION;
        pos_angle        = hssp_pkg::ANGLE_HIGH;
        goal_angle       = hssp_pkg::ANGLE_HIGH;
        slewing          = 1'b0;
        last_step_ms     = '0;
        return_ms        = '0;
        fired_hour       = hssp_pkg::NO_HOUR;
    endfunction

    function automatic hssp_pkg::t_result next_position(hssp_pkg::t_tick t);
        hssp_pkg::t_result r;
        int nxt;
        logic [31:0] since_step;
        r.position_written = 1'b0;
        r.reached          = 1'b0;
        if (t.time_valid) begin
            if (t.minute == 6'd0 && t.hour != fired_hour) begin
                goal_angle = hssp_pkg::ANGLE_LOW;
                slewing    = 1'b1;
                fired_hour = t.hour;
                return_ms  = t.now_ms + {10'd0, hold_ms};
            end
            if (goal_angle == hssp_pkg::ANGLE_LOW && t.now_ms >= return_ms) begin
                goal_angle = hssp_pkg::ANGLE_HIGH;
                slewing    = 1'b1;
            end
            since_step = t.now_ms - last_step_ms;
            if (since_step >= {16'd0, step_interval_ms}) begin
                if (pos_angle != goal_angle) begin
                    if (goal_angle > pos_angle)
                        nxt = int'(pos_angle) + int'(step_deg);
                    else
                        nxt = int'(pos_angle) - int'(step_deg);
                    if (nxt < int'(hssp_pkg::ANGLE_LOW))
                        nxt = int'(hssp_pkg::ANGLE_LOW);
                    else if (nxt > int'(hssp_pkg::ANGLE_HIGH))
                        nxt = int'(hssp_pkg::ANGLE_HIGH);
                    pos_angle          = 8'(nxt);
                    last_step_ms       = t.now_ms;
                    r.position_written = 1'b1;
                end else if (slewing) begin
                    slewing   = 1'b0;
                    r.reached = 1'b1;
                end
            end
        end
        r.position_deg = pos_angle;
        r.moving       = slewing;
        return r;
    endfunction

    function automatic hssp_pkg::t_tick mk_tick(logic [31:0] now, logic valid,
                                                logic [4:0] hour, logic [5:0] minute);
        hssp_pkg::t_tick t;
        t.now_ms     = now;
        t.time_valid = valid;
        t.hour       = hour;
        t.minute     = minute;
        return t;
    endfunction

    function automatic hssp_pkg::t_tick random_tick();
        hssp_pkg::t_tick t;
        int unsigned pick;
        int unsigned dt_kind;
        logic [31:0] dt;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // noise: invalid time with arbitrary fields
            return mk_tick($urandom(), 1'b0, 5'($urandom_range(0, 31)),
                           6'($urandom_range(0, 63)));
        end
        case ($urandom_range(0, 9))
            0: begin
                wall_min  = 0;
                wall_hour = (wall_hour + 1) % 24;
            end
            1, 2: begin
                wall_min = wall_min + $urandom_range(1, 15);
                if (wall_min >= 60) begin
                    wall_min  = wall_min - 60;
                    wall_hour = (wall_hour + 1) % 24;
                end
            end
            default: ;
        endcase
        dt_kind = $urandom_range(0, 19);
        if (dt_kind < 14)
            dt = $urandom_range(0, 2 * int'(step_interval_ms) + 1);
        else if (dt_kind < 18)
            dt = $urandom_range(0, int'(hold_ms) + int'(hold_ms) / 2 + 1);
        else if (dt_kind == 18)
            dt = '0;
        else
            dt = $urandom();
        sim_ms = sim_ms + dt;
        t = mk_tick(sim_ms, 1'b1, 5'(wall_hour), 6'(wall_min));
        if (pick < 13) begin
            // valid time but off-range or arbitrary hour and minute
            t.hour   = 5'($urandom_range(0, 31));
            t.minute = ($urandom_range(0, 2) == 0) ? 6'd0 : 6'($urandom_range(0, 63));
        end
        return t;
    endfunction

    task automatic write_reg(input logic [hssp_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [hssp_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        case (addr)
            hssp_pkg::CFG_UPDATE_INTERVAL: step_interval_ms = data[15:0];
            hssp_pkg::CFG_STEP_DEGREES:    step_deg = data[6:0];
            hssp_pkg::CFG_HOLD_DURATION:   hold_ms = data[21:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] interval, input logic [6:0] stp,
                                  input logic [21:0] hold);
        write_reg(hssp_pkg::CFG_UPDATE_INTERVAL, {6'd0, interval});
        write_reg(hssp_pkg::CFG_STEP_DEGREES, {15'd0, stp});
        write_reg(hssp_pkg::CFG_HOLD_DURATION, hold);
        settings_used++;
    endtask

    // sample between edges so the sender's beat state has settled
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || s_axis_tvalid || expected_positions.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_random(input int unsigned n);
        sim_ms    = $urandom();
        wall_hour = $urandom_range(0, 23);
        wall_min  = $urandom_range(0, 59);
        repeat (n) pending_ticks.push_back(random_tick());
        wait_drained();
    endtask

    // sender: one beat held until accepted, then the next one or a gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_positions.push_back(next_position(tick_on_bus));
                ticks_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    tick_on_bus = pending_ticks.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'd0, tick_on_bus.minute, tick_on_bus.hour,
                                      tick_on_bus.now_ms};
                    s_axis_tuser  <= tick_on_bus.time_valid;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (backpressure_req && !backpressure_done) begin
            m_axis_tready <= 1'b0;
            backpressure_cycles++;
            if (backpressure_cycles == LONG_HOLD)
                backpressure_done = 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // scoreboard
    always @(posedge i_clk) begin
        hssp_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_positions.size() == 0) begin
                error_cnt++;
                if (error_cnt <= 10)
                    $display("unexpected beat: deg=%0d tuser=%b", m_axis_tdata, m_axis_tuser);
            end else begin
                want = expected_positions.pop_front();
                beats_checked++;
                if (m_axis_tdata != want.position_deg
                        || m_axis_tuser[0] != want.position_written
                        || m_axis_tuser[1] != want.moving
                        || m_axis_tuser[2] != want.reached) begin
                    error_cnt++;
                    if (error_cnt <= 10)
                        $display("beat %0d: exp deg=%0d wr/mov/rch=%b%b%b, got deg=%0d %b%b%b",
                                 beats_checked, want.position_deg, want.position_written,
                                 want.moving, want.reached, m_axis_tdata, m_axis_tuser[0],
                                 m_axis_tuser[1], m_axis_tuser[2]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        servo_reset_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed ticks under reset settings
        pending_ticks.push_back(mk_tick(32'hFFFF_FFFF, 1'b0, 5'd31, 6'd63));
        pending_ticks.push_back(mk_tick(32'd0, 1'b1, 5'd31, 6'd0));     // hour 31 never fires
        pending_ticks.push_back(mk_tick(32'd100, 1'b1, 5'd5, 6'd30));
        pending_ticks.push_back(mk_tick(32'd200, 1'b1, 5'd5, 6'd0));    // top of hour
        pending_ticks.push_back(mk_tick(32'd205, 1'b1, 5'd5, 6'd0));    // same hour again
        pending_ticks.push_back(mk_tick(32'd225, 1'b1, 5'd5, 6'd0));
        pending_ticks.push_back(mk_tick(32'd230, 1'b1, 5'd25, 6'd0));   // hour out of range
        pending_ticks.push_back(mk_tick(32'd60230, 1'b1, 5'd25, 6'd1)); // deadline hit
        pending_ticks.push_back(mk_tick(32'd60250, 1'b1, 5'd25, 6'd2));
        pending_ticks.push_back(mk_tick(32'd60270, 1'b1, 5'd25, 6'd3)); // reached
        pending_ticks.push_back(mk_tick(32'd60290, 1'b1, 5'd25, 6'd4));
        pending_ticks.push_back(mk_tick(32'hFFFF_FF00, 1'b1, 5'd6, 6'd0)); // wrapped deadline
        pending_ticks.push_back(mk_tick(32'h0000_0010, 1'b1, 5'd6, 6'd0));
        pending_ticks.push_back(mk_tick(32'd1000, 1'b1, 5'd7, 6'd0));
        pending_ticks.push_back(mk_tick(32'd1019, 1'b1, 5'd7, 6'd0));  // one short of interval
        pending_ticks.push_back(mk_tick(32'd1020, 1'b1, 5'd7, 6'd0));  // exactly one interval
        pending_ticks.push_back(mk_tick(32'd1030, 1'b0, 5'd8, 6'd0));  // invalid top of hour
        pending_ticks.push_back(mk_tick(32'd1035, 1'b1, 5'd9, 6'd1));
        pending_ticks.push_back(mk_tick(32'd1040, 1'b1, 5'd0, 6'd0));
        pending_ticks.push_back(mk_tick(32'd1060, 1'b1, 5'd0, 6'd59));
        wait_drained();

        // interval of one ms, step spanning the whole clamp range, zero hold
        apply_settings(16'd1, 7'd90, 22'd0);
        run_random(PHASE_TICKS);

        send_idle_pct = 55;
        recv_idle_pct = 24;
        apply_settings(16'd65535, 7'd1, 22'd3600000);
        run_random(PHASE_TICKS);

        // zero interval and zero step, hold at full register width
        apply_settings(16'd0, 7'd0, 22'h3F_FFFF);
        run_random(PHASE_TICKS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings(16'($urandom_range(1, 100)), 7'd127, 22'($urandom_range(0, 20000)));
        backpressure_req = 1'b1;
        run_random(PHASE_TICKS);

        apply_settings(16'($urandom_range(1, 60)), 7'($urandom_range(2, 45)),
                       22'($urandom_range(50, 8000)));
        run_random(PHASE_TICKS);

        repeat (10) @(posedge i_clk);
        $display("sent %0d ticks across %0d register settings, checked %0d result beats",
                 ticks_sent, settings_used, beats_checked);
        $display("mismatches: %0d, long output stall: %0d cycles",
                 error_cnt, backpressure_cycles);
        if (error_cnt == 0 && expected_positions.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
hdl/hssp_pkg.sv
hdl/hssp_slew.sv
hdl/hourly_servo_slew_positioner.sv
hdl/hssp_checker.sv
tb/tb_hourly_servo_slew_positioner.sv
